// ===== rtl/pfp_pkg.sv =====
// Package for the polygon stream frame parser: codes, types and helper functions.
`default_nettype none
package pfp_pkg;

    localparam int unsigned VERTEX_TABLE_DEPTH_DEF = 256;

    // parse phases
    localparam logic [3:0] PH_FLAGS  = 4'd0;
    localparam logic [3:0] PH_MASK_H = 4'd1;
    localparam logic [3:0] PH_MASK_L = 4'd2;
    localparam logic [3:0] PH_COL_H  = 4'd3;
    localparam logic [3:0] PH_COL_L  = 4'd4;
    localparam logic [3:0] PH_VCOUNT = 4'd5;
    localparam logic [3:0] PH_LOAD_X = 4'd6;
    localparam logic [3:0] PH_LOAD_Y = 4'd7;
    localparam logic [3:0] PH_DESC   = 4'd8;
    localparam logic [3:0] PH_VX     = 4'd9;
    localparam logic [3:0] PH_VY     = 4'd10;
    localparam logic [3:0] PH_VIDX   = 4'd11;

    // result kinds
    localparam logic [2:0] KIND_CLEAR      = 3'd0;
    localparam logic [2:0] KIND_PALETTE    = 3'd1;
    localparam logic [2:0] KIND_POLY       = 3'd2;
    localparam logic [2:0] KIND_VERTEX     = 3'd3;
    localparam logic [2:0] KIND_END        = 3'd4;
    localparam logic [2:0] KIND_END_NEXT   = 3'd5;
    localparam logic [2:0] KIND_RESTART    = 3'd6;

    // frame end bytes
    localparam logic [7:0] BYTE_END        = 8'hff;
    localparam logic [7:0] BYTE_END_NEXT   = 8'hfe;
    localparam logic [7:0] BYTE_RESTART    = 8'hfd;

    // screen offsets
    localparam logic [9:0] X_OFS_LO = 10'd32;
    localparam logic [9:0] X_OFS_HI = 10'd64;
    localparam logic [8:0] Y_OFS_HI = 9'd20;

    typedef struct packed {
        logic [3:0]  phase;
        logic        indexed;
        logic [15:0] mask;
        logic [3:0]  slot;
        logic [7:0]  held;
        logic [7:0]  to_load;
        logic [7:0]  load_pos;
        logic [3:0]  remaining;
        logic [3:0]  count;
        logic [3:0]  color;
    } t_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] color_index;
        logic [3:0] vertex_count;
        logic [9:0] screen_x;
        logic [8:0] screen_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_vertex;
        logic [2:0] end_code;
    } t_result;

    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [15:0] data;
    } t_vwrite;

    // slot of the highest set mask bit; bit 15 is slot 0
    function automatic logic [3:0] top_slot(input logic [15:0] m);
        logic [3:0] s;
        s = 4'd15;
        for (int i = 15; i >= 0; i--) begin
            if (m[15 - i]) begin
                s = 4'(i);
            end
        end
        return s;
    endfunction

    // 3-bit palette component moved to the top of a byte
    function automatic logic [7:0] comp(input logic [2:0] c);
        return {c, 5'd0};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/pfp_parser.sv =====
// Per-byte parse logic: next parser state, result item and vertex table write.
`default_nettype none
module pfp_parser #(
    parameter int unsigned VERTEX_TABLE_DEPTH = pfp_pkg::VERTEX_TABLE_DEPTH_DEF
) (
    input  wire logic            i_hires,
    input  wire logic [7:0]      i_byte,
    input  wire logic [15:0]     i_entry,
    input  wire pfp_pkg::t_state i_state,
    output      pfp_pkg::t_state o_state,
    output      logic            o_has_result,
    output      pfp_pkg::t_result o_result,
    output      pfp_pkg::t_vwrite o_write
);

    localparam logic [8:0] DEPTH_9 = 9'(VERTEX_TABLE_DEPTH);

    pfp_pkg::t_state  s;
    pfp_pkg::t_result res;
    pfp_pkg::t_vwrite wr;
    logic             has;
    logic [15:0]      mask_new;
    logic [7:0]       pos_new;
    logic [7:0]       vx;
    logic [7:0]       vy;
    logic [3:0]       rem_new;
    logic [3:0]       mode_ph;

    always_comb begin
        s        = i_state;
        res      = '0;
        wr       = '0;
        has      = 1'b0;
        mask_new = '0;
        pos_new  = '0;
        vx       = '0;
        vy       = '0;
        rem_new  = '0;
        mode_ph  = i_state.indexed ? pfp_pkg::PH_VCOUNT : pfp_pkg::PH_DESC;

        case (i_state.phase)
            pfp_pkg::PH_FLAGS: begin
                s.indexed = i_byte[2];
                if (i_byte[0]) begin
                    res.kind = pfp_pkg::KIND_CLEAR;
                    has      = 1'b1;
                end
                if (i_byte[1]) begin
                    s.phase = pfp_pkg::PH_MASK_H;
                end else begin
                    s.phase = i_byte[2] ? pfp_pkg::PH_VCOUNT : pfp_pkg::PH_DESC;
                end
            end
            pfp_pkg::PH_MASK_H: begin
                s.held  = i_byte;
                s.phase = pfp_pkg::PH_MASK_L;
            end
            pfp_pkg::PH_MASK_L: begin
                mask_new = {i_state.held, i_byte};
                s.mask   = mask_new;
                if (mask_new != '0) begin
                    s.slot  = pfp_pkg::top_slot(mask_new);
                    s.phase = pfp_pkg::PH_COL_H;
                end else begin
                    s.slot  = '0;
                    s.phase = mode_ph;
                end
            end
            pfp_pkg::PH_COL_H: begin
                s.held  = i_byte;
                s.phase = pfp_pkg::PH_COL_L;
            end
            pfp_pkg::PH_COL_L: begin
                res.kind        = pfp_pkg::KIND_PALETTE;
                res.color_index = i_state.slot;
                res.red         = pfp_pkg::comp(i_state.held[2:0]);
                res.green       = pfp_pkg::comp(i_byte[6:4]);
                res.blue        = pfp_pkg::comp(i_byte[2:0]);
                has             = 1'b1;
                mask_new        = i_state.mask & ~(16'h8000 >> i_state.slot);
                s.mask          = mask_new;
                if (mask_new != '0) begin
                    s.slot  = pfp_pkg::top_slot(mask_new);
                    s.phase = pfp_pkg::PH_COL_H;
                end else begin
                    s.phase = mode_ph;
                end
            end
            pfp_pkg::PH_VCOUNT: begin
                s.to_load  = i_byte;
                s.load_pos = '0;
                s.phase    = (i_byte != '0) ? pfp_pkg::PH_LOAD_X : pfp_pkg::PH_DESC;
            end
            pfp_pkg::PH_LOAD_X: begin
                s.held  = i_byte;
                s.phase = pfp_pkg::PH_LOAD_Y;
            end
            pfp_pkg::PH_LOAD_Y: begin
                wr.en      = ({1'b0, i_state.load_pos} < DEPTH_9);
                wr.addr    = i_state.load_pos;
                wr.data    = {i_state.held, i_byte};
                pos_new    = i_state.load_pos + 8'd1;
                s.load_pos = pos_new;
                s.phase    = (pos_new == i_state.to_load) ? pfp_pkg::PH_DESC
                                                          : pfp_pkg::PH_LOAD_X;
            end
            pfp_pkg::PH_DESC: begin
                has = 1'b1;
                if (i_byte == pfp_pkg::BYTE_END || i_byte == pfp_pkg::BYTE_END_NEXT
                        || i_byte == pfp_pkg::BYTE_RESTART) begin
                    if (i_byte == pfp_pkg::BYTE_END) begin
                        res.kind = pfp_pkg::KIND_END;
                    end else if (i_byte == pfp_pkg::BYTE_END_NEXT) begin
                        res.kind = pfp_pkg::KIND_END_NEXT;
                    end else begin
                        res.kind = pfp_pkg::KIND_RESTART;
                    end
                    res.end_code = res.kind;
                    s.phase      = pfp_pkg::PH_FLAGS;
                end else begin
                    s.color          = i_byte[7:4];
                    s.count          = i_byte[3:0];
                    s.remaining      = i_byte[3:0];
                    res.kind         = pfp_pkg::KIND_POLY;
                    res.color_index  = i_byte[7:4];
                    res.vertex_count = i_byte[3:0];
                    if (i_byte[3:0] != '0) begin
                        s.phase = i_state.indexed ? pfp_pkg::PH_VIDX : pfp_pkg::PH_VX;
                    end
                end
            end
            pfp_pkg::PH_VX: begin
                s.held  = i_byte;
                s.phase = pfp_pkg::PH_VY;
            end
            pfp_pkg::PH_VY, pfp_pkg::PH_VIDX: begin
                // direct mode keeps the x byte from earlier; indexed reads the table
                if (i_state.phase == pfp_pkg::PH_VY) begin
                    vx = i_state.held;
                    vy = i_byte;
                end else begin
                    vx = i_entry[15:8];
                    vy = i_entry[7:0];
                end
                rem_new          = i_state.remaining - 4'd1;
                s.remaining      = rem_new;
                has              = 1'b1;
                res.kind         = pfp_pkg::KIND_VERTEX;
                res.color_index  = i_state.color;
                res.vertex_count = i_state.count;
                if (i_hires) begin
                    res.screen_x = pfp_pkg::X_OFS_HI + {1'b0, vx, 1'b0};
                    res.screen_y = pfp_pkg::Y_OFS_HI + {1'b0, vy};
                end else begin
                    res.screen_x = pfp_pkg::X_OFS_LO + {2'b00, vx};
                    res.screen_y = {1'b0, vy};
                end
                res.last_vertex = (rem_new == '0);
                if (rem_new == '0) begin
                    s.phase = pfp_pkg::PH_DESC;
                end
            end
            default: begin
                s.phase = pfp_pkg::PH_FLAGS;
            end
        endcase
    end

    assign o_state      = s;
    assign o_result     = res;
    assign o_has_result = has;
    assign o_write      = wr;

endmodule
`default_nettype wire

// ===== rtl/polygon_stream_frame_parser.sv =====
// Top level of the polygon stream frame parser.
// Takes one stream byte per cycle while the output is not stalled and gives at most one result
// item per byte, back to back. A byte is registered on acceptance, parsed by one stage of logic
// once the output register is free or being emptied; its result lands in the output register.
// Unless stalled, the parse stage sets the rate of one byte per cycle. The vertex table is a
// RAM read with the accepted byte as address, so indexed vertices see the entry in the parse
// cycle. Per-entry valid bits make unloaded entries read as zero right after reset; there is
// no clearing pass. The table is kept across frames. The resolution mode may only be written
// while idle.
`default_nettype none
module polygon_stream_frame_parser #(
    parameter int unsigned VERTEX_TABLE_DEPTH = pfp_pkg::VERTEX_TABLE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output      logic       o_cfg_ready,
    input  wire logic       i_cfg_data,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire logic [7:0] i_stream_byte,
    output      logic       o_out_valid,
    input  wire logic       i_out_ready,
    output      logic [2:0] o_kind,
    output      logic [3:0] o_color_index,
    output      logic [3:0] o_vertex_count,
    output      logic [9:0] o_screen_x,
    output      logic [8:0] o_screen_y,
    output      logic [7:0] o_red,
    output      logic [7:0] o_green,
    output      logic [7:0] o_blue,
    output      logic       o_last_vertex,
    output      logic [2:0] o_end_code
);

    localparam int unsigned AW      = $clog2(VERTEX_TABLE_DEPTH);
    localparam logic [8:0]  DEPTH_9 = 9'(VERTEX_TABLE_DEPTH);

    logic                    r_hires;
    logic                    r_in_valid;
    logic [7:0]              r_byte;
    pfp_pkg::t_state         r_state;
    pfp_pkg::t_state         n_state;
    logic                    r_out_valid;
    pfp_pkg::t_result        r_out;
    pfp_pkg::t_result        w_result;
    logic                    w_has_result;
    pfp_pkg::t_vwrite        w_write;
    logic [VERTEX_TABLE_DEPTH-1:0] r_entry_ok;
    logic [15:0]             w_rdata;
    logic [15:0]             w_entry;
    logic                    w_go;
    logic                    w_accept;

    // parse stage advances when the output register is free or being emptied
    assign w_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hires <= 1'b0;
        end else if (i_cfg_valid) begin
            r_hires <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_stream_byte;
        end
    end

    pfp_ram #(
        .WIDTH (16),
        .DEPTH (VERTEX_TABLE_DEPTH)
    ) u_vtable (
        .i_clk   (i_clk),
        .i_we    (w_go && w_write.en),
        .i_waddr (w_write.addr[AW-1:0]),
        .i_wdata (w_write.data),
        .i_re    (w_accept),
        .i_raddr (i_stream_byte[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_ok <= '0;
        end else if (w_go && w_write.en) begin
            r_entry_ok[w_write.addr[AW-1:0]] <= 1'b1;
        end
    end

    // out-of-range or never loaded entries read as zero
    assign w_entry = (({1'b0, r_byte} < DEPTH_9) && r_entry_ok[r_byte[AW-1:0]])
                   ? w_rdata : 16'd0;

    pfp_parser #(
        .VERTEX_TABLE_DEPTH (VERTEX_TABLE_DEPTH)
    ) u_parser (
        .i_hires      (r_hires),
        .i_byte       (r_byte),
        .i_entry      (w_entry),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_has_result (w_has_result),
        .o_result     (w_result),
        .o_write      (w_write)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_color_index  = r_out.color_index;
    assign o_vertex_count = r_out.vertex_count;
    assign o_screen_x     = r_out.screen_x;
    assign o_screen_y     = r_out.screen_y;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_last_vertex  = r_out.last_vertex;
    assign o_end_code     = r_out.end_code;

endmodule
`default_nettype wire
